// ----- src/sfla_pkg.sv -----
// Shared types and constants for the strip/fan to list index assembler.
package sfla_pkg;

  localparam int unsigned IDX_W      = 16;
  localparam int unsigned SLOT_W     = 17;
  localparam int unsigned SLOT_LIMIT = 131072;
  localparam int unsigned BURST_MAX  = 3;

  typedef enum logic [2:0] {
    KIND_TRILIST   = 3'd0,
    KIND_TRISTRIP  = 3'd1,
    KIND_TRIFAN    = 3'd2,
    KIND_LINELIST  = 3'd3,
    KIND_POLYLINE  = 3'd4,
    KIND_POINTLIST = 3'd5
  } prim_kind_e;

  typedef struct packed {
    logic             mode;
    logic [2:0]       prim_kind;
    logic [IDX_W-1:0] index_value;
    logic             sequential;
    logic             last_item;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic [SLOT_W-1:0] out_slot;
    logic [2:0]        out_kind;
    logic              run_last;
    logic              overflow;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] older;
    logic [IDX_W-1:0] newer;
  } hist_t;

  typedef struct packed {
    out_word_t [BURST_MAX-1:0] word;
    logic [1:0]                cnt;
  } burst_t;

endpackage

// ----- src/sfla_conv.sv -----
// Converts one input word and the primitive history into up to three list words.
module sfla_conv import sfla_pkg::*; #(
  parameter int unsigned CAP = 131072
) (
  input  in_word_t                    item_i,
  input  hist_t                       hist_i,
  input  logic [$clog2(CAP+1)-1:0]    slot_cnt_i,
  output hist_t                       hist_o,
  output logic [$clog2(CAP+1)-1:0]    slot_cnt_o,
  output burst_t                      burst_o
);

  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned SUM_W = CNT_W + 2;

  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] idx [BURST_MAX];
  logic [2:0]       kind;
  logic [1:0]       n;
  logic [SUM_W-1:0] sum [BURST_MAX];
  logic [SUM_W-1:0] total;

  always_comb begin
    cur  = item_i.sequential ? hist_i.pos : item_i.index_value;
    n    = 2'd0;
    kind = 3'(KIND_TRILIST);
    for (int k = 0; k < BURST_MAX; k++) begin
      idx[k] = '0;
    end

    case (prim_kind_e'(item_i.prim_kind))
      KIND_TRILIST, KIND_LINELIST, KIND_POINTLIST: begin
        idx[0] = cur;
        kind   = item_i.prim_kind;
        n      = 2'd1;
      end
      KIND_TRISTRIP: begin
        if (hist_i.pos >= IDX_W'(2)) begin
          if (hist_i.pos[0]) begin
            idx[0] = hist_i.newer;
            idx[1] = hist_i.older;
          end else begin
            idx[0] = hist_i.older;
            idx[1] = hist_i.newer;
          end
          idx[2] = cur;
          n      = 2'd3;
        end
      end
      KIND_TRIFAN: begin
        if (hist_i.pos >= IDX_W'(2)) begin
          idx[0] = hist_i.first;
          idx[1] = hist_i.newer;
          idx[2] = cur;
          n      = 2'd3;
        end
      end
      KIND_POLYLINE: begin
        if (hist_i.pos != '0) begin
          idx[0] = hist_i.newer;
          idx[1] = cur;
          kind   = 3'(KIND_LINELIST);
          n      = 2'd2;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase

    if (item_i.mode) begin
      n = 2'd0;
    end

    for (int k = 0; k < BURST_MAX; k++) begin
      sum[k] = SUM_W'(slot_cnt_i) + SUM_W'(k);
      burst_o.word[k].out_index = idx[k];
      burst_o.word[k].out_kind  = kind;
      burst_o.word[k].run_last  = (2'(k + 1) == n);
      if (sum[k] < SUM_W'(CAP)) begin
        burst_o.word[k].out_slot = SLOT_W'(sum[k]);
        burst_o.word[k].overflow = 1'b0;
      end else begin
        burst_o.word[k].out_slot = SLOT_W'(CAP - 1);
        burst_o.word[k].overflow = 1'b1;
      end
    end
    burst_o.cnt = n;

    total = SUM_W'(slot_cnt_i) + SUM_W'(n);
    if (item_i.mode) begin
      slot_cnt_o = '0;
    end else if (total > SUM_W'(CAP)) begin
      slot_cnt_o = CNT_W'(CAP);
    end else begin
      slot_cnt_o = CNT_W'(total);
    end

    hist_o = hist_i;
    if (!item_i.mode) begin
      if (hist_i.pos == '0) begin
        hist_o.first = cur;
      end
      hist_o.older = hist_i.newer;
      hist_o.newer = cur;
      hist_o.pos   = item_i.last_item ? '0 : hist_i.pos + IDX_W'(1);
    end
  end

endmodule

// ----- src/strip_fan_to_list_index_assembler_top.sv -----
// Top level of the strip/fan to list index assembler.
//
//   channel  dir  handshake              word
//   in       in   in_valid_i/in_stall_o    in_word_t  (one source index or a flush)
//   out      out  out_valid_o/out_stall_i  out_word_t (one list index with its slot)
//
// An input word is converted in the cycle it is accepted; its zero to three
// results leave the burst register one per cycle through the output register
// while the output is not stalled.
// The next word is taken in the cycle the last result moves to the output.
// Reset clears primitive history, the slot counter and all valid state.
// An output stall holds the output word and backs up into in_stall_o.
module strip_fan_to_list_index_assembler_top import sfla_pkg::*; #(
  parameter int unsigned INDEX_BUFFER_DEPTH = 131072
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned CAP   = (INDEX_BUFFER_DEPTH > SLOT_LIMIT) ? SLOT_LIMIT
                                                                     : INDEX_BUFFER_DEPTH;
  localparam int unsigned CNT_W = $clog2(CAP + 1);

  hist_t            hist_q, hist_d;
  logic [CNT_W-1:0] slot_q, slot_d;
  burst_t           burst_d;
  out_word_t        words_q [BURST_MAX];
  logic [1:0]       rem_q;
  logic             out_valid_q;
  out_word_t        out_word_q;
  logic             out_load;
  logic             in_accept;

  sfla_conv #(
    .CAP(CAP)
  ) u_conv (
    .item_i     (in_word_i),
    .hist_i     (hist_q),
    .slot_cnt_i (slot_q),
    .hist_o     (hist_d),
    .slot_cnt_o (slot_d),
    .burst_o    (burst_d)
  );

  assign out_load   = (rem_q != 2'd0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((rem_q == 2'd0) || ((rem_q == 2'd1) && out_load));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      slot_q      <= '0;
      rem_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        hist_q <= hist_d;
        slot_q <= slot_d;
        rem_q  <= burst_d.cnt;
      end else if (out_load) begin
        rem_q <= rem_q - 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int k = 0; k < BURST_MAX; k++) begin
        words_q[k] <= burst_d.word[k];
      end
    end else if (out_load) begin
      for (int k = 0; k < BURST_MAX - 1; k++) begin
        words_q[k] <= words_q[k+1];
      end
    end
    if (out_load) begin
      out_word_q <= words_q[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- src/sfla_checker.sv -----
// Port-level checks for the strip/fan to list index assembler, bound to the top level.
module sfla_checker import sfla_pkg::*; #(
  parameter int unsigned INDEX_BUFFER_DEPTH = 131072
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  localparam int unsigned CAP = (INDEX_BUFFER_DEPTH > SLOT_LIMIT) ? SLOT_LIMIT
                                                                   : INDEX_BUFFER_DEPTH;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  a_ovf_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.overflow |-> out_word_o.out_slot == SLOT_W'(CAP - 1))
    else $error("overflow word not at top slot");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.out_kind == 3'(KIND_TRILIST))
                 || (out_word_o.out_kind == 3'(KIND_LINELIST))
                 || (out_word_o.out_kind == 3'(KIND_POINTLIST)))
    else $error("output kind is not a list kind");

endmodule

bind strip_fan_to_list_index_assembler_top sfla_checker #(
  .INDEX_BUFFER_DEPTH(INDEX_BUFFER_DEPTH)
) u_sfla_checker (.*);
